/* hdl/ppf_pkg.sv */
// Package for the printer packet framer: payload structs, mode codes and
// protocol constants. Used by ppf_framer, ppf_burst and printer_packet_framer.
`timescale 1ns / 1ps
`default_nettype none

package ppf_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_BODY   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_REPLY  = 2'd3
  } mode_t;

  // Protocol bytes
  localparam logic [7:0] SyncFirst  = 8'h88;
  localparam logic [7:0] SyncSecond = 8'h33;
  localparam logic [7:0] AckA       = 8'h80;
  localparam logic [7:0] AckB       = 8'h81;

  // Longest burst of results from one item, and counter width
  localparam int FrameMax = 6;
  localparam int CountW   = $clog2(FrameMax + 1);

  localparam logic [CountW-1:0] CountStart  = CountW'(6);
  localparam logic [CountW-1:0] CountBody   = CountW'(1);
  localparam logic [CountW-1:0] CountFinish = CountW'(4);
  localparam logic [CountW-1:0] CountReply  = CountW'(1);

  // Input transaction
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  command;
    logic        compression;
    logic [15:0] body_length;
    logic [7:0]  data_byte;
    logic [7:0]  reply_byte;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       reply_valid;
    logic       ack_ok;
    logic [7:0] status_byte;
  } result_t;

  // Burst description handed from the framer to the burst stage
  typedef struct packed {
    logic [FrameMax-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     is_reply;
    logic                     ack_ok;
    logic [7:0]               status;
  } frame_t;

endpackage

`default_nettype wire

/* hdl/ppf_framer.sv */
// Framer stage: turns one item into a burst description and keeps the
// running checksum. Depends on ppf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppf_framer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ppf_pkg::item_t item,
  input  wire logic           load,
  output ppf_pkg::frame_t     frame
);

  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic [9:0]  header_sum;
  logic        ack_match;

  // Header checksum: command + compression + length low + length high
  assign header_sum = {2'b00, item.command} + {9'd0, item.compression}
                    + {2'b00, item.body_length[7:0]} + {2'b00, item.body_length[15:8]};

  assign ack_match = (item.reply_byte == ppf_pkg::AckA) ||
                     (item.reply_byte == ppf_pkg::AckB);

  // Burst contents and checksum update per mode
  always_comb begin
    frame            = '0;
    running_sum_next = running_sum;
    case (item.mode)
      ppf_pkg::MODE_START: begin
        frame.bytes[0]   = ppf_pkg::SyncFirst;
        frame.bytes[1]   = ppf_pkg::SyncSecond;
        frame.bytes[2]   = item.command;
        frame.bytes[3]   = {7'd0, item.compression};
        frame.bytes[4]   = item.body_length[7:0];
        frame.bytes[5]   = item.body_length[15:8];
        frame.count      = ppf_pkg::CountStart;
        running_sum_next = {6'd0, header_sum};
      end
      ppf_pkg::MODE_BODY: begin
        frame.bytes[0]   = item.data_byte;
        frame.count      = ppf_pkg::CountBody;
        running_sum_next = running_sum + {8'd0, item.data_byte};
      end
      ppf_pkg::MODE_FINISH: begin
        // checksum low, high, then two idle slots for ack and status
        frame.bytes[0] = running_sum[7:0];
        frame.bytes[1] = running_sum[15:8];
        frame.count    = ppf_pkg::CountFinish;
      end
      ppf_pkg::MODE_REPLY: begin
        frame.count    = ppf_pkg::CountReply;
        frame.is_reply = 1'b1;
        frame.ack_ok   = ack_match;
        frame.status   = item.reply_byte;
      end
      default: begin
        frame = '0;
      end
    endcase
  end

  // Checksum register, updated on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (load) begin
      running_sum <= running_sum_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/ppf_burst.sv */
// Burst stage: holds one item's results in a shift register and moves them
// one per cycle, while the output register is free, into the output register. Depends on ppf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppf_burst (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ppf_pkg::frame_t frame,
  input  wire logic            load,
  output logic                 busy_stall,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output ppf_pkg::result_t     result
);

  logic                                 busy;
  logic [ppf_pkg::CountW-1:0]           remaining;
  logic [ppf_pkg::FrameMax-1:0][7:0]    bytes;
  logic                                 is_reply;
  logic                                 ack_ok;
  logic [7:0]                           status;
  logic                                 advance;
  logic                                 final_one;
  ppf_pkg::result_t                     result_next;

  // Move the head of the burst whenever the output register is free
  assign advance    = busy && (!result_valid || !result_stall);
  assign final_one  = (remaining == ppf_pkg::CountW'(1));
  assign busy_stall = busy && !(advance && final_one);

  // Result built from the head of the burst
  always_comb begin
    result_next             = '0;
    result_next.last        = final_one;
    result_next.reply_valid = is_reply;
    if (is_reply) begin
      result_next.ack_ok      = ack_ok;
      result_next.status_byte = status;
    end else begin
      result_next.tx_byte = bytes[0];
    end
  end

  // Control: burst occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      remaining    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        busy      <= 1'b1;
        remaining <= frame.count;
      end else if (advance) begin
        remaining <= remaining - ppf_pkg::CountW'(1);
        if (final_one) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload: burst shift register and output register
  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= frame.bytes;
      is_reply <= frame.is_reply;
      ack_ok   <= frame.ack_ok;
      status   <= frame.status;
    end else if (advance) begin
      bytes <= bytes >> 8;
    end
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remaining != '0) && (remaining <= ppf_pkg::CountW'(ppf_pkg::FrameMax)))
    else $error("burst count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (advance && final_one)))
    else $error("new burst loaded over a pending one");

  a_reply_no_tx: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.reply_valid) |-> (result.tx_byte == 8'd0) && result.last)
    else $error("reply result carries a transmit byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && final_one && !load) |=> !busy)
    else $error("burst stage still busy after last result");
`endif

endmodule

`default_nettype wire

/* hdl/printer_packet_framer.sv */
// Top level of the printer packet framer: ppf_framer feeding ppf_burst.
// Depends on ppf_pkg, ppf_framer and ppf_burst.
//
// Usage:
//   item channel   : item_valid / item_stall / item (ppf_pkg::item_t). A
//                    transaction is taken on a clock edge with item_valid high
//                    and item_stall low.
//   result channel : result_valid / result_stall / result (ppf_pkg::result_t).
//                    A start item yields 6 results, finish 4, body and reply 1;
//                    the final result of each item has last set.
//   Path           : an item taken goes into the burst shift register, and its
//                    first result then moves to the output register once free.
//   Throughput     : one result per cycle when the output register is free,
//                    set by the single burst shift register; an item holds it
//                    until all its results have left, and the next item is
//                    taken in the cycle the last result before it leaves.
//   Stall          : on a stalled valid result the output register holds, the
//                    burst stops, and item_stall rises once a burst is pending.
//   Reset          : rst (synchronous) empties both stages and clears the
//                    running checksum to zero.
`timescale 1ns / 1ps
`default_nettype none

module printer_packet_framer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire ppf_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output ppf_pkg::result_t      result
);

  logic            accept;
  ppf_pkg::frame_t frame;

  assign accept = item_valid && !item_stall;

  ppf_framer u_framer (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .load  (accept),
    .frame (frame)
  );

  ppf_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .load         (accept),
    .busy_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
